// File: src/amcd_pkg.sv
// Package for the AM modulator and coherent demodulator: types, constants and ROM builders.
`default_nettype none
package amcd_pkg;

  localparam int TAP_COUNT         = 101;
  localparam int COSINE_TABLE_BITS = 10;

  localparam int QuarterPoints = 1 << COSINE_TABLE_BITS;
  localparam int CosAddrW      = COSINE_TABLE_BITS + 1;
  localparam int TapW          = $clog2(TAP_COUNT);
  localparam int CntW          = $clog2(TAP_COUNT + 1);

  localparam int SampleW = 16;
  localparam int CoefW   = 18;
  localparam int ProdW   = 18;
  localparam int McW     = 33;
  localparam int ModW    = 49;
  localparam int PwW     = 65;
  localparam int MacW    = CoefW + ProdW;
  localparam int AccW    = 44;
  localparam int GainW   = 16;
  localparam int TW      = AccW + GainW + 1;

  localparam longint OneQ30    = 64'sd1073741824;
  localparam longint PiQ30     = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint HamAQ30   = 64'sd579820585;
  localparam longint HamBQ30   = 64'sd493921239;
  localparam int     OutLimit  = 32763;
  localparam int     ProdLimit = 131071;
  localparam int     ModFrac   = 45;
  localparam int     DemFrac   = 44;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP  = 2'd0;
  localparam logic [1:0] REG_DEPTH = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;

  typedef struct packed {
    logic signed [SampleW-1:0] x;
    logic signed [SampleW-1:0] c;
  } sample_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MC, ST_MOD, ST_PROD, ST_WRITE, ST_MAC, ST_GAIN, ST_OUT
  } back_state_e;

  typedef logic [15:0] cos_rom_t [QuarterPoints+1];
  typedef logic signed [CoefW-1:0] fir_rom_t [TAP_COUNT];

  // Restoring long division of unsigned 64-bit values, used while building the ROMs.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Signed division that truncates toward zero.
  function automatic longint sdiv64(input longint n, input longint d);
    logic [63:0] q;
    q = udiv64((n < 0) ? 64'(-n) : 64'(n), (d < 0) ? 64'(-d) : 64'(d));
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Q30 Taylor series of sine or cosine for an angle in the first quadrant.
  function automatic longint series_q30(input logic [63:0] theta, input bit want_sin);
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] a;
    longint      sum;
    t2   = (theta * theta) >> 30;
    term = want_sin ? theta : 64'(OneQ30);
    a    = want_sin ? 64'd2 : 64'd1;
    sum  = longint'(term);
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * t2) >> 30, a * (a + 64'd1));
      a    = a + 64'd2;
      if (i % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return sum;
  endfunction

  function automatic longint turn_cos_q30(input logic [31:0] turn);
    logic [63:0] theta;
    theta = ({34'd0, turn[29:0]} * 64'(HalfPiQ30)) >> 30;
    unique case (turn[31:30])
      2'd0:    return series_q30(theta, 1'b0);
      2'd1:    return -series_q30(theta, 1'b1);
      2'd2:    return -series_q30(theta, 1'b0);
      default: return series_q30(theta, 1'b1);
    endcase
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b) / OneQ30;
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint   c;
    longint   v;
    for (int j = 0; j <= QuarterPoints; j++) begin
      c = turn_cos_q30(32'(j << (30 - COSINE_TABLE_BITS)));
      v = (c < 0) ? 64'sd0 : ((c + 64'sd16384) >>> 15);
      rom[j] = (v > 64'sd32767) ? 16'd32767 : v[15:0];
    end
    return rom;
  endfunction

  function automatic fir_rom_t build_fir_rom();
    fir_rom_t    rom;
    longint      h [TAP_COUNT];
    longint      total;
    longint      sinc;
    longint      win;
    longint      s;
    longint      mag;
    longint      r;
    logic [31:0] sturn;
    logic [31:0] wturn;
    int          k;
    int          ak;
    total = 0;
    for (int n = 0; n < TAP_COUNT; n++) begin
      k  = n - TAP_COUNT / 2;
      ak = (k < 0) ? -k : k;
      if (ak == 0) begin
        sinc = (OneQ30 * 4) / 25;
      end else begin
        sturn = 32'(((64'((2 * ak) % 25)) << 32) / 64'd25);
        s     = turn_cos_q30(sturn - 32'h4000_0000);
        sinc  = sdiv64(s * OneQ30, PiQ30 * longint'(ak));
      end
      wturn = 32'(((64'(n % (TAP_COUNT - 1))) << 32) / 64'(TAP_COUNT - 1));
      win   = HamAQ30 - mul_q30(HamBQ30, turn_cos_q30(wturn));
      h[n]  = mul_q30(sinc, win);
      total = total + h[n];
    end
    if (total < 1) total = 1;
    for (int n = 0; n < TAP_COUNT; n++) begin
      mag    = (h[n] < 0) ? -h[n] : h[n];
      r      = sdiv64(mag * 131072 + total / 2, total);
      rom[n] = (h[n] < 0) ? CoefW'(-r) : CoefW'(r);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();
  localparam fir_rom_t FIR_ROM = build_fir_rom();

  // Saturating truncation of a Q(frac) value to the output PCM scale.
  function automatic logic signed [15:0] to_pcm(input logic signed [63:0] v, input int frac);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    if (mag >= (64'd1 << frac)) begin
      q = 64'(OutLimit);
    end else begin
      q = ((mag << 15) - mag) >> frac;
      if (q > 64'(OutLimit)) q = 64'(OutLimit);
    end
    return v[63] ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

endpackage
`default_nettype wire

// File: src/amcd_front.sv
// Front part: accepts samples, runs the carrier oscillator and looks up the carrier.
`default_nettype none
module amcd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [31:0]       step_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [15:0]       in_data_i,
  output logic                   push_o,
  input  wire logic              push_ready_i,
  output amcd_pkg::sample_t      push_data_o
);
  import amcd_pkg::*;

  logic [31:0]               phase_q;
  logic                      hold_q;
  logic signed [SampleW-1:0] x_q;
  logic [1:0]                quad_q;
  logic [15:0]               rom_q;
  logic [CosAddrW-1:0]       addr;
  logic [COSINE_TABLE_BITS-1:0] j;
  logic                      accept;

  assign in_ready_o = !hold_q;
  assign accept     = in_valid_i && in_ready_o;
  assign j          = phase_q[29 -: COSINE_TABLE_BITS];
  assign addr       = phase_q[30] ? (CosAddrW'(QuarterPoints) - CosAddrW'(j)) : CosAddrW'(j);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      hold_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_q + step_i;
        hold_q  <= 1'b1;
      end else if (push_o && push_ready_i) begin
        hold_q <= 1'b0;
      end
    end
  end

  // Carrier ROM with registered read data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= $signed(in_data_i);
      quad_q <= phase_q[31:30];
      rom_q  <= COS_ROM[addr];
    end
  end

  assign push_o        = hold_q;
  assign push_data_o.x = x_q;
  assign push_data_o.c = (quad_q == 2'd1 || quad_q == 2'd2) ? -$signed(rom_q) : $signed(rom_q);

endmodule
`default_nettype wire

// File: src/amcd_queue.sv
// Two-entry queue that decouples the front and back parts.
`default_nettype none
module amcd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   push_ready_o,
  input  wire amcd_pkg::sample_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_i,
  output amcd_pkg::sample_t      pop_data_o
);
  import amcd_pkg::*;

  sample_t    slot_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// File: src/amcd_back.sv
// Back part: modulation, product, FIR delay line memory and shared multiply-accumulate.
`default_nettype none
module amcd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       depth_i,
  input  wire logic [15:0]       gain_i,
  input  wire logic              pop_valid_i,
  output logic                   pop_o,
  input  wire amcd_pkg::sample_t pop_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [31:0]            out_data_o
);
  import amcd_pkg::*;

  back_state_e state_q, state_d;

  logic signed [SampleW-1:0] x_q, c_q, ymod_q, ymod_o_q, ydem_o_q;
  logic signed [McW-1:0]     mc_q;
  logic signed [ModW-1:0]    mod_q;
  logic signed [PwW-1:0]     prod_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [TW-1:0]      t_q;
  logic signed [ProdW-1:0]   mem [TAP_COUNT];
  logic signed [ProdW-1:0]   rd_q;
  logic signed [CoefW-1:0]   coef_q;
  logic signed [MacW-1:0]    mprod_q;
  logic [TapW-1:0]           wp_q, ra_q;
  logic [CntW-1:0]           fill_q, k_q;
  logic                      en1_q, iv1_q, iv2_q, out_v_q;

  logic                      issue, mem_we, out_load, mac_done;
  logic [PwW-1:0]            pmag;
  logic signed [ProdW-1:0]   pval;

  assign mac_done = (k_q == CntW'(TAP_COUNT)) && !iv1_q && !iv2_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (pop_valid_i) state_d = ST_MC;
      ST_MC:    state_d = ST_MOD;
      ST_MOD:   state_d = ST_PROD;
      ST_PROD:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_MAC;
      ST_MAC:   if (mac_done) state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_OUT;
      ST_OUT:   if (!out_v_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == ST_IDLE) && pop_valid_i;
    mem_we   = (state_q == ST_WRITE);
    issue    = (state_q == ST_MAC) && (k_q != CntW'(TAP_COUNT));
    out_load = (state_q == ST_OUT) && (!out_v_q || out_ready_i);
  end

  // Product taken to Q2.15 by truncation toward zero, then saturated.
  always_comb begin
    pmag = prod_q[PwW-1] ? PwW'(-prod_q) : PwW'(prod_q);
    pmag = pmag >> ModFrac;
    if (pmag > PwW'(ProdLimit)) pmag = PwW'(ProdLimit);
    pval = prod_q[PwW-1] ? -$signed(pmag[ProdW-1:0]) : $signed(pmag[ProdW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      fill_q  <= '0;
      k_q     <= '0;
      iv1_q   <= 1'b0;
      iv2_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iv1_q   <= issue;
      iv2_q   <= iv1_q;
      if (mem_we) begin
        wp_q   <= (wp_q == TapW'(TAP_COUNT - 1)) ? '0 : wp_q + 1'b1;
        fill_q <= (fill_q == CntW'(TAP_COUNT)) ? fill_q : fill_q + 1'b1;
        k_q    <= '0;
      end else if (issue) begin
        k_q <= k_q + 1'b1;
      end
      if (out_load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q <= pop_data_i.x;
      c_q <= pop_data_i.c;
    end
    if (state_q == ST_MC) mc_q <= $signed({1'b0, depth_i}) * c_q + McW'(OneQ30);
    if (state_q == ST_MOD) mod_q <= x_q * mc_q;
    if (state_q == ST_PROD) begin
      prod_q <= mod_q * c_q;
      ymod_q <= to_pcm(64'(mod_q), ModFrac);
    end
    if (mem_we) begin
      mem[wp_q] <= pval;
      ra_q      <= wp_q;
      acc_q     <= '0;
    end
    if (issue) begin
      rd_q   <= mem[ra_q];
      coef_q <= FIR_ROM[k_q[TapW-1:0]];
      en1_q  <= (k_q < fill_q);
      ra_q   <= (ra_q == '0) ? TapW'(TAP_COUNT - 1) : ra_q - 1'b1;
    end
    if (iv1_q) mprod_q <= coef_q * $signed(en1_q ? rd_q : ProdW'(0));
    if (iv2_q) acc_q <= acc_q + AccW'(mprod_q);
    if (state_q == ST_GAIN) t_q <= acc_q * $signed({1'b0, gain_i});
    if (out_load) begin
      ymod_o_q <= ymod_q;
      ydem_o_q <= to_pcm(64'(t_q), DemFrac);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = {ydem_o_q, ymod_o_q};

endmodule
`default_nettype wire

// File: src/am_modulator_coherent_demodulator_core.sv
// Top level of the AM modulator with coherent demodulator.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[15:0] audio_sample
//   m_axis    out        tdata[15:0] modulated_sample, tdata[31:16] demodulated_sample
//   cfg       in         cfg_index_i selects step, depth or gain; cfg_data_i is the value
//
// In the back part one request at a time goes through the single shared
// multiply-accumulate, fed by one delay line memory read per cycle. The front
// part takes a new request while the back part works.
// Reset clears the oscillator phase, the delay line fill count and all handshakes;
// taps never written read as zero. A finished result waits in the output register
// while the next request is already being computed, so a stalled master side only
// stops the block once that register, the back part, the queue and the front register are all full.
`default_nettype none
module am_modulator_coherent_demodulator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] audio_sample
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [15:0] modulated_sample, [31:16] demodulated_sample
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import amcd_pkg::*;

  logic [31:0] step_q;
  logic [15:0] depth_q;
  logic [15:0] gain_q;

  logic    push, push_ready, pop, pop_valid;
  sample_t push_data, pop_data;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      depth_q <= 16'd32768;
      gain_q  <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STEP:  step_q  <= cfg_data_i;
        REG_DEPTH: depth_q <= cfg_data_i[15:0];
        REG_GAIN:  gain_q  <= cfg_data_i[15:0];
        default:   ;
      endcase
    end
  end

  amcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  amcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  amcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .depth_i     (depth_q),
    .gain_i      (gain_q),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // The back part only takes a request the queue actually holds.
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid) else $error("back part popped an empty queue");

  // A front request waiting on a full queue is not lost or overwritten.
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !push_ready |=> push && $stable(push_data)) else $error("front request dropped");

  // Both results stay within the saturation limit.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[15:0]) <= 16'sd32763 &&
                         $signed(m_axis_tdata_o[15:0]) >= -16'sd32763 &&
                         $signed(m_axis_tdata_o[31:16]) <= 16'sd32763 &&
                         $signed(m_axis_tdata_o[31:16]) >= -16'sd32763))
    else $error("result outside saturation range");

endmodule
`default_nettype wire

// File: bench/am_modulator_coherent_demodulator_core_tb.sv
// Self-checking testbench for the AM modulator and coherent demodulator core.
`timescale 1ns / 1ps
`default_nettype none
module am_modulator_coherent_demodulator_core_tb;
  import amcd_pkg::*;

  // Index that names no register; writes to it must be ignored.
  localparam logic [1:0] RegUnused = 2'd3;

  // Predicts the modulated and demodulated samples of each request and keeps
  // them in order until the block hands back the matching result.
  class am_scoreboard;
    logic [31:0]        phase_step;
    logic [15:0]        depth;
    logic [15:0]        gain;
    logic [31:0]        phase;
    longint             taps [TAP_COUNT];
    logic signed [15:0] cos_table [QuarterPoints+1];
    longint             coefs [TAP_COUNT];
    logic [31:0]        pending_results [$];
    int                 mismatches;

    function new();
      cos_table_fill();
      mismatches = 0;
      clear();
    endfunction

    // The cosine table and the filter taps are recomputed here, the taps from the windowed-sinc definition.
    function void cos_table_fill();
      longint      h [TAP_COUNT];
      longint      total;
      longint      sinc;
      longint      win;
      longint      c;
      longint      mag;
      longint      r;
      logic [31:0] sturn;
      logic [31:0] wturn;
      int          ak;
      for (int j = 0; j <= QuarterPoints; j++) begin
        c = cos_turn(32'(j << (30 - COSINE_TABLE_BITS)));
        c = (c < 0) ? 0 : ((c + 16384) >>> 15);
        cos_table[j] = (c > 32767) ? 16'sd32767 : 16'(c);
      end
      total = 0;
      for (int n = 0; n < TAP_COUNT; n++) begin
        ak = n - TAP_COUNT / 2;
        if (ak < 0) ak = -ak;
        if (ak == 0) begin
          sinc = (64'sd1073741824 * 4) / 25;
        end else begin
          sturn = 32'(((64'((2 * ak) % 25)) << 32) / 64'd25);
          sinc = (cos_turn(sturn - 32'h4000_0000) * 64'sd1073741824) /
                 (64'sd3373259426 * longint'(ak));
        end
        wturn = 32'(((64'(n % (TAP_COUNT - 1))) << 32) / 64'(TAP_COUNT - 1));
        win = 64'sd579820585 - (64'sd493921239 * cos_turn(wturn)) / 64'sd1073741824;
        h[n] = (sinc * win) / 64'sd1073741824;
        total += h[n];
      end
      if (total < 1) total = 1;
      for (int n = 0; n < TAP_COUNT; n++) begin
        mag = (h[n] < 0) ? -h[n] : h[n];
        r = (mag * 131072 + total / 2) / total;
        coefs[n] = (h[n] < 0) ? -r : r;
      end
    endfunction

    // Truncated Taylor series in Q30, angle in the first quadrant.
    function longint taylor(logic [63:0] theta, bit want_sin);
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] a;
      longint      sum;
      t2 = (theta * theta) >> 30;
      term = want_sin ? theta : 64'd1073741824;
      a = want_sin ? 64'd2 : 64'd1;
      sum = longint'(term);
      for (int i = 1; i <= 12; i++) begin
        term = ((term * t2) >> 30) / (a * (a + 64'd1));
        a += 64'd2;
        if (i % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      return sum;
    endfunction

    function longint cos_turn(logic [31:0] turn);
      logic [63:0] theta;
      theta = ({34'd0, turn[29:0]} * 64'd1686629713) >> 30;
      case (turn[31:30])
        2'd0: return taylor(theta, 0);
        2'd1: return -taylor(theta, 1);
        2'd2: return -taylor(theta, 0);
        default: return taylor(theta, 1);
      endcase
    endfunction

    function void clear();
      phase_step = 0;
      depth = 16'd32768;
      gain = 16'd4096;
      phase = 0;
      foreach (taps[k]) taps[k] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_STEP:  phase_step = value;
        REG_DEPTH: depth = value[15:0];
        REG_GAIN:  gain = value[15:0];
        default: ;
      endcase
    endfunction

    // Saturate a value with the given number of fraction bits to PCM.
    function logic [15:0] pcm(longint v, int frac);
      longint m;
      longint q;
      m = (v < 0) ? -v : v;
      if (m >= (64'sd1 << frac)) q = OutLimit;
      else begin
        q = (m * 32767) >>> frac;
        if (q > OutLimit) q = OutLimit;
      end
      return 16'((v < 0) ? -q : q);
    endfunction

    function void note_request(logic signed [15:0] x);
      logic [9:0] j;
      longint     c;
      longint     modv;
      logic signed [127:0] prod;
      logic [127:0] pmag;
      longint     p;
      longint     acc;
      logic signed [127:0] scaled;
      j = phase[29:20];
      case (phase[31:30])
        2'd0: c = cos_table[j];
        2'd1: c = -cos_table[QuarterPoints - j];
        2'd2: c = -cos_table[j];
        default: c = cos_table[QuarterPoints - j];
      endcase
      phase += phase_step;
      modv = longint'(x) * (64'sd1073741824 + longint'(depth) * c);
      prod = 128'(modv) * 128'(c);
      pmag = (prod < 0) ? -prod : prod;
      pmag = pmag >> 45;
      p = (pmag > ProdLimit) ? ProdLimit : longint'(pmag);
      if (prod < 0) p = -p;
      for (int k = TAP_COUNT - 1; k > 0; k--) taps[k] = taps[k-1];
      taps[0] = p;
      acc = 0;
      for (int k = 0; k < TAP_COUNT; k++) acc += coefs[k] * taps[k];
      scaled = 128'(acc) * 128'(longint'(gain));
      pending_results.push_back({pcm(longint'(scaled), DemFrac), pcm(modv, ModFrac)});
    endfunction

    // Prints one line for a mismatch and counts it.
    task report(string what);
      $display("%s", what);
      mismatches++;
    endtask

    task check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h arrived with nothing outstanding", got));
        return;
      end
      want = pending_results.pop_front();
      if (got[15:0] !== want[15:0])
        report($sformatf("modulated_sample: got %0d, want %0d",
                         $signed(got[15:0]), $signed(want[15:0])));
      if (got[31:16] !== want[31:16])
        report($sformatf("demodulated_sample: got %0d, want %0d",
                         $signed(got[31:16]), $signed(want[31:16])));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;    // [15:0] audio_sample
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;    // [15:0] modulated_sample, [31:16] demodulated_sample
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  am_scoreboard sb;
  int  sender_idle_pct;    // Chance per cycle that the sender offers nothing.
  int  receiver_stall_pct; // Chance per cycle that the receiver holds off.
  int  hold_off_cycles;    // Pending long receiver hold-off, counted below.

  am_modulator_coherent_demodulator_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous cap on the run time; if it is reached the test reports a failure.
  initial begin
    #(64'd2000 * 111 * 10 * 10);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, plus a long counted hold-off on request.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offer one request and hold it until the block takes it. The valid line
  // stays up between back-to-back requests and drops only while idling.
  task automatic send_sample(logic [15:0] x);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= x;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(x);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Registers are only touched once the pipeline has emptied.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly plausible audio, with full-scale and rail values mixed in.
  function automatic logic [15:0] random_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(8000)) - 4000);
    endcase
  endfunction

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++) send_sample(random_sample());
  endtask

  logic [15:0] directed [] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                               16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000};

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_STEP;
    cfg_data_i = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero step keeps the carrier at full positive.
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // Depth above one, maximum gain, quarter-turn step to hit every quadrant.
    write_reg(REG_STEP, 32'h4000_0000);
    write_reg(REG_DEPTH, 32'h0000_FFFF);
    write_reg(REG_GAIN, 32'h0000_FFFF);
    write_reg(RegUnused, 32'hDEAD_BEEF);
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // Zero depth and gain, then the largest phase step.
    write_reg(REG_DEPTH, 32'd0);
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    random_burst(5);
    drain();

    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      sender_idle_pct    = (phase_no == 1 || phase_no == 3) ? 64 : 0;
      receiver_stall_pct = (phase_no == 2) ? 64 : (phase_no == 3 ? 19 : 0);
      if (phase_no == 3) sender_idle_pct = 19;
      write_reg(REG_STEP, 32'($urandom));
      write_reg(REG_DEPTH, 32'($urandom_range(32768)));
      write_reg(REG_GAIN, $urandom_range(1) ? 32'd4096 : 32'($urandom_range(65535)));
      if (phase_no == 0) hold_off_cycles = 3000;  // block fills and stalls input
      random_burst(225);
      drain();
    end

    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
src/amcd_pkg.sv
src/amcd_front.sv
src/amcd_queue.sv
src/amcd_back.sv
src/am_modulator_coherent_demodulator_core.sv
bench/am_modulator_coherent_demodulator_core_tb.sv
